@@ src/sfb_pkg.sv @@
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, codes and defaults for the SYN flood blacklister.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_BAN_DEPTH   = 32;
    localparam int MAX_RESULTS     = 32;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic EV_BAN   = 1'b0;
    localparam logic EV_UNBAN = 1'b1;

    localparam logic [1:0] REG_MAX_SYN   = 2'd0;
    localparam logic [1:0] REG_PERIOD    = 2'd1;
    localparam logic [1:0] REG_PROBATION = 2'd2;

    localparam logic [15:0] RST_MAX_SYN   = 16'd1;
    localparam logic [15:0] RST_PERIOD    = 16'd1;
    localparam logic [15:0] RST_PROBATION = 16'd300;

    typedef struct packed {
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] port;
    } t_key;

    // search word walking down the cell chain
    typedef struct packed {
        logic active;
        logic found;
        logic ban;
        logic free_ok;
    } t_token;

    typedef struct packed {
        t_key        key;
        logic [31:0] stamp;
    } t_ban;

endpackage

@@ src/sfb_cell.sv @@
// ----------------------------------------------------------------------------
// sfb_cell
// One counter table entry: key, SYN count and valid bit, with a registered
// hop of the search word towards the next cell.
// ----------------------------------------------------------------------------
module sfb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfb_pkg::t_key   i_key,
    input  logic [15:0]     i_max_syn,
    input  logic            i_clear,
    input  logic            i_insert,
    input  sfb_pkg::t_token i_tok,
    output sfb_pkg::t_token o_tok
);
    import sfb_pkg::*;

    logic        r_valid;
    logic        r_claim;
    t_key        r_key;
    logic [15:0] r_count;
    t_token      r_tok;
    t_token      n_tok;
    logic [15:0] w_cnt_inc;
    logic        w_hit;
    logic        w_free;
    logic        w_ban;

    always_comb begin
        w_cnt_inc = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
        w_hit     = i_tok.active && r_valid && (r_key == i_key) && !i_tok.found;
        w_free    = i_tok.active && !r_valid && !i_tok.free_ok;
        w_ban     = w_cnt_inc > i_max_syn;
        n_tok     = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.ban   = w_ban;
        end
        if (w_free) begin
            n_tok.free_ok = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_claim <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            // remember whether this cell was the lowest free one
            if (i_tok.active) begin
                r_claim <= w_free;
            end
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (w_hit && w_ban) begin
                r_valid <= 1'b0;
            end else if (i_insert && r_claim) begin
                r_valid <= (i_max_syn != 16'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_count <= w_cnt_inc;
        end
        if (i_insert && r_claim) begin
            r_key   <= i_key;
            r_count <= 16'd1;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ src/syn_flood_blacklister_top.sv @@
// ----------------------------------------------------------------------------
// syn_flood_blacklister_top
// Per-key SYN counting in a chain of table cells with a timed blacklist.
// ----------------------------------------------------------------------------
// A SYN packet walks the key table one cell per clock, so busy stays high until
// the search word leaves the last cell; a ban, if any, is strobed in the cycle
// after. Packets without SYN are taken with busy low. A tick holds busy over a
// read and an evaluate state, repeated per unban as the blacklist read is
// registered; each unban is strobed from the next evaluate state. Results are
// strobed on o_valid for one cycle and cannot be held off, so sample them as they go.
module syn_flood_blacklister_top #(
    parameter int TABLE_DEPTH = sfb_pkg::DEF_TABLE_DEPTH,
    parameter int BAN_DEPTH   = sfb_pkg::DEF_BAN_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic        i_syn_flag,
    input  logic        i_addr_is_v6,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [15:0] i_target_port,
    output logic        o_valid,
    output logic        o_event_res,
    output logic        o_out_is_v6,
    output logic [63:0] o_out_addr_high,
    output logic [63:0] o_out_addr_low,
    output logic [15:0] o_out_port,
    output logic        o_queued,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfb_pkg::*;

    localparam int HEAD_W = $clog2(BAN_DEPTH);
    localparam int FILL_W = $clog2(BAN_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam int N_W    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_READ, S_EVAL} t_state;

    t_state          r_state;
    logic [15:0]     r_max_syn;
    logic [15:0]     r_period;
    logic [15:0]     r_probation;
    logic [31:0]     r_seconds;
    logic [15:0]     r_elapsed;
    logic [HEAD_W-1:0] r_head;
    logic [FILL_W-1:0] r_fill;
    logic [N_W-1:0]  r_n;
    logic            r_pend;
    t_key            r_pend_key;
    t_key            r_key;
    t_token          r_launch;
    t_ban            r_rd;
    t_ban            r_mem [BAN_DEPTH];

    t_token          w_chain [TABLE_DEPTH+1];
    t_key            w_in_key;
    logic            w_accept;
    logic            w_cfg_wr;
    logic [15:0]     w_elapsed_inc;
    logic            w_clear;
    logic            w_done;
    logic            w_insert;
    logic            w_ban;
    logic            w_room;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_wrap;
    logic [HEAD_W-1:0] w_tail;
    logic [HEAD_W-1:0] w_head_inc;
    logic [31:0]     w_age;
    logic            w_expire;

    assign w_in_key = '{v6: i_addr_is_v6, hi: i_addr_high, lo: i_addr_low,
                        port: i_target_port};
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign w_elapsed_inc = r_elapsed + 16'd1;
    assign w_clear  = w_accept && (i_kind == KIND_TICK) && (w_elapsed_inc >= r_period);

    assign w_done   = (r_state == S_SEARCH) && w_chain[TABLE_DEPTH].active;
    assign w_insert = w_done && !w_chain[TABLE_DEPTH].found && w_chain[TABLE_DEPTH].free_ok;
    assign w_ban    = w_chain[TABLE_DEPTH].found ? w_chain[TABLE_DEPTH].ban
                                                 : (w_insert && (r_max_syn == 16'd0));
    assign w_room   = r_fill < FILL_W'(BAN_DEPTH);

    assign w_sum      = SUM_W'(r_head) + SUM_W'(r_fill);
    assign w_wrap     = w_sum - SUM_W'(BAN_DEPTH);
    assign w_tail     = (w_sum >= SUM_W'(BAN_DEPTH)) ? HEAD_W'(w_wrap) : HEAD_W'(w_sum);
    assign w_head_inc = (r_head == HEAD_W'(BAN_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign w_age    = r_seconds - r_rd.stamp;
    assign w_expire = (r_fill != '0) && (r_n < N_W'(MAX_RESULTS))
                      && (w_age >= {16'd0, r_probation});

    // cell chain
    assign w_chain[0] = r_launch;
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        sfb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key     (r_key),
            .i_max_syn (r_max_syn),
            .i_clear   (w_clear),
            .i_insert  (w_insert),
            .i_tok     (w_chain[g]),
            .o_tok     (w_chain[g+1])
        );
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_SYN:   prdata = {16'd0, r_max_syn};
            REG_PERIOD:    prdata = {16'd0, r_period};
            REG_PROBATION: prdata = {16'd0, r_probation};
            default:       prdata = 32'd0;
        endcase
    end

    // blacklist memory
    always_ff @(posedge i_clk) begin
        if (w_done && w_ban && w_room) begin
            r_mem[w_tail] <= '{key: r_key, stamp: r_seconds};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_syn   <= RST_MAX_SYN;
            r_period    <= RST_PERIOD;
            r_probation <= RST_PROBATION;
            r_seconds   <= 32'd0;
            r_elapsed   <= 16'd0;
            r_head      <= '0;
            r_fill      <= '0;
            r_n         <= '0;
            r_pend      <= 1'b0;
            r_launch    <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_launch <= '0;
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    REG_MAX_SYN:   r_max_syn   <= pwdata[15:0];
                    REG_PERIOD:    r_period    <= pwdata[15:0];
                    REG_PROBATION: r_probation <= pwdata[15:0];
                    default:       ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_kind == KIND_TICK) begin
                        r_seconds <= r_seconds + 32'd1;
                        r_elapsed <= w_clear ? 16'd0 : w_elapsed_inc;
                        r_n       <= '0;
                        r_pend    <= 1'b0;
                        r_state   <= S_READ;
                    end else if (w_accept && i_syn_flag) begin
                        r_launch <= '{active: 1'b1, found: 1'b0, ban: 1'b0, free_ok: 1'b0};
                        r_state  <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_done) begin
                        if (w_ban) begin
                            o_valid     <= 1'b1;
                            o_event_res <= EV_BAN;
                            o_queued    <= w_room;
                            o_last      <= 1'b1;
                            if (w_room) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_expire) begin
                        r_pend  <= 1'b1;
                        r_head  <= w_head_inc;
                        r_fill  <= r_fill - 1'b1;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_IDLE;
                    end
                    // release the held unban, marking it final when the run ends
                    if (r_pend) begin
                        o_valid     <= 1'b1;
                        o_event_res <= EV_UNBAN;
                        o_queued    <= 1'b1;
                        o_last      <= !w_expire;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_in_key;
        end
        if (r_state == S_EVAL && w_expire) begin
            r_pend_key <= r_rd.key;
        end
        if (r_state == S_SEARCH) begin
            o_out_is_v6     <= r_key.v6;
            o_out_addr_high <= r_key.hi;
            o_out_addr_low  <= r_key.lo;
            o_out_port      <= r_key.port;
        end else if (r_state == S_EVAL) begin
            o_out_is_v6     <= r_pend_key.v6;
            o_out_addr_high <= r_pend_key.hi;
            o_out_addr_low  <= r_pend_key.lo;
            o_out_port      <= r_pend_key.port;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BAN_DEPTH))
        else $error("blacklist fill beyond depth");

    a_ban_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_res == EV_BAN) |-> (o_last && $past(r_state) == S_SEARCH))
        else $error("ban not single final word");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_TICK) |=> (r_state == S_READ))
        else $error("tick did not start blacklist ageing");

    a_unban_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && w_expire) |-> (r_n < N_W'(MAX_RESULTS)))
        else $error("too many unbans in one tick");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the SYN flood blacklister: a scoreboard predicts ban and
// unban words from accepted packets and ticks, and checks every strobed word.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfb_pkg::*;

    localparam int TDEPTH = DEF_TABLE_DEPTH;
    localparam int BDEPTH = DEF_BAN_DEPTH;

    typedef struct packed {
        logic        ev;
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] port;
        logic        queued;
        logic        last;
    } t_word;

    class flood_scoreboard;
        logic [15:0] max_syn, period, probation;
        bit          ent_valid [TDEPTH];
        t_key        ent_key   [TDEPTH];
        logic [15:0] ent_count [TDEPTH];
        t_key        bl_key    [BDEPTH];
        logic [31:0] bl_time   [BDEPTH];
        int unsigned head, fill;
        logic [31:0] now;
        logic [15:0] elapsed;
        t_word       pending[$];
        int          errors, bans, unbans, ticks, packets;

        function void reset_state();
            max_syn = RST_MAX_SYN; period = RST_PERIOD; probation = RST_PROBATION;
            foreach (ent_valid[i]) ent_valid[i] = 0;
            head = 0; fill = 0; now = 0; elapsed = 0;
            pending.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] v);
            case (idx)
                REG_MAX_SYN:   max_syn = v;
                REG_PERIOD:    period = v;
                REG_PROBATION: probation = v;
                default: ;
            endcase
        endfunction

        function void note_input(logic kind, logic syn, t_key k);
            int slot, fr, n;
            logic [15:0] c;
            t_word w;
            if (kind == KIND_PACKET) begin
                packets++;
                if (!syn) return;
                slot = -1; fr = -1;
                for (int i = 0; i < TDEPTH; i++) begin
                    if (ent_valid[i]) begin
                        if (slot < 0 && ent_key[i] == k) slot = i;
                    end else if (fr < 0) fr = i;
                end
                if (slot < 0) begin
                    if (fr < 0) return;
                    slot = fr; ent_valid[slot] = 1; ent_key[slot] = k;
                    ent_count[slot] = 0;
                end
                c = ent_count[slot];
                if (c != 16'hFFFF) c++;
                ent_count[slot] = c;
                if (c <= max_syn) return;
                w.ev = EV_BAN; w.v6 = k.v6; w.hi = k.hi; w.lo = k.lo; w.port = k.port;
                w.queued = fill < BDEPTH; w.last = 1;
                if (w.queued) begin
                    bl_key[(head + fill) % BDEPTH] = k;
                    bl_time[(head + fill) % BDEPTH] = now;
                    fill++;
                end
                ent_valid[slot] = 0;
                pending.push_back(w);
                bans++;
            end else begin
                ticks++;
                now++;
                elapsed++;
                if (elapsed >= period) begin
                    foreach (ent_valid[i]) ent_valid[i] = 0;
                    elapsed = 0;
                end
                n = 0;
                while (fill > 0 && n < MAX_RESULTS) begin
                    if (32'(now - bl_time[head]) < 32'(probation)) break;
                    w.ev = EV_UNBAN; w.v6 = bl_key[head].v6; w.hi = bl_key[head].hi;
                    w.lo = bl_key[head].lo; w.port = bl_key[head].port;
                    w.queued = 1; w.last = 0;
                    pending.push_back(w);
                    n++; unbans++;
                    head = (head + 1) % BDEPTH; fill--;
                end
                if (n > 0) pending[$].last = 1;
            end
        endfunction

        function void check_word(t_word a);
            t_word e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word ev=%0b port=%h", a.ev, a.port);
                return;
            end
            e = pending.pop_front();
            if (a != e) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp ev%0b v6%0b %h_%h p%h q%0b l%0b",
                             e.ev, e.v6, e.hi, e.lo, e.port, e.queued, e.last);
                    $display("         got ev%0b v6%0b %h_%h p%h q%0b l%0b",
                             a.ev, a.v6, a.hi, a.lo, a.port, a.queued, a.last);
                end
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, start, busy;
    logic        i_kind, i_syn_flag, i_addr_is_v6;
    logic [63:0] i_addr_high, i_addr_low;
    logic [15:0] i_target_port;
    logic        o_valid, o_event_res, o_out_is_v6, o_queued, o_last;
    logic [63:0] o_out_addr_high, o_out_addr_low;
    logic [15:0] o_out_port;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;

    flood_scoreboard sb;
    int  stall_cycles;
    bit  calm;
    t_key pool[8];

    syn_flood_blacklister_top DUT (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // results are strobed for one cycle only; sample every edge
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_valid) begin
            w.ev = o_event_res; w.v6 = o_out_is_v6; w.hi = o_out_addr_high;
            w.lo = o_out_addr_low; w.port = o_out_port; w.queued = o_queued;
            w.last = o_last;
            sb.check_word(w);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    // wait for every predicted word, then let the block settle
    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TDEPTH + 8) @(posedge i_clk);
    endtask

    // start stays high after the accepting edge until the next word or an idle
    // cycle replaces it
    task automatic send(logic kind, logic syn, t_key k);
        if (!calm) while ($urandom_range(99) < 19) begin
            start <= 0;
            i_kind <= 1'($urandom); i_syn_flag <= 1'($urandom);
            @(posedge i_clk);
        end
        start <= 1; i_kind <= kind; i_syn_flag <= syn; i_addr_is_v6 <= k.v6;
        i_addr_high <= k.hi; i_addr_low <= k.lo; i_target_port <= k.port;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(kind, syn, k);
    endtask

    function automatic t_key rand_key();
        t_key k;
        k.v6 = 1'($urandom); k.hi = {$urandom, $urandom}; k.lo = {$urandom, $urandom};
        k.port = 16'($urandom);
        if (!k.v6) begin k.hi = 0; k.lo[63:32] = 0; end
        return k;
    endfunction

    initial begin
        t_key k, z, f;
        sb = new();
        sb.reset_state();
        calm = 0;
        i_rst_n = 0; start = 0; i_kind = 0; i_syn_flag = 0; i_addr_is_v6 = 0;
        i_addr_high = 0; i_addr_low = 0; i_target_port = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (pool[i]) pool[i] = rand_key();

        // directed: defaults, extremes of fields, queue full, largest threshold
        z = '0; f = '1;
        send(KIND_PACKET, 1'b0, f);
        send(KIND_PACKET, 1'b1, z); send(KIND_PACKET, 1'b1, z);
        send(KIND_PACKET, 1'b1, f); send(KIND_PACKET, 1'b1, f);
        k = f; k.port = 0;
        send(KIND_PACKET, 1'b1, k); send(KIND_TICK, 1'b0, z);
        drain();
        write_reg(REG_MAX_SYN, 0); write_reg(REG_PROBATION, 0);
        write_reg(REG_PERIOD, 16'hFFFF);
        send(KIND_PACKET, 1'b1, f); send(KIND_TICK, 1'b1, f); send(KIND_TICK, 1'b0, z);
        drain();
        write_reg(REG_PROBATION, 2);
        for (int i = 0; i < 34; i++) begin
            k = rand_key();
            send(KIND_PACKET, 1'b1, k);
        end
        drain();
        send(KIND_TICK, 1'b0, z); send(KIND_TICK, 1'b0, z); send(KIND_TICK, 1'b0, z);
        drain();
        write_reg(REG_MAX_SYN, 16'hFFFF); write_reg(REG_PERIOD, 0);
        send(KIND_PACKET, 1'b1, f); send(KIND_PACKET, 1'b1, f); send(KIND_TICK, 1'b0, z);
        drain();

        // random phases with varying settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_MAX_SYN, ph == 3 ? 16'($urandom) : 16'($urandom_range(3)));
            write_reg(REG_PERIOD, 16'($urandom_range(1, 6)));
            write_reg(REG_PROBATION, ph == 2 ? 16'($urandom) : 16'($urandom_range(4)));
            calm = (ph == 1);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(99) < 20)
                    send(KIND_TICK, 1'($urandom), rand_key());
                else if ($urandom_range(99) < 10)
                    send(KIND_PACKET, 1'b0, rand_key());
                else if ($urandom_range(99) < 80)
                    send(KIND_PACKET, 1'b1, pool[$urandom_range(7)]);
                else
                    send(KIND_PACKET, 1'b1, rand_key());
            end
            drain();
        end
        calm = 0;
        write_reg(REG_PROBATION, 0);
        send(KIND_TICK, 1'b0, z);
        drain();

        $display("covered %0d packets, %0d ticks, %0d bans, %0d unbans",
                 sb.packets, sb.ticks, sb.bans, sb.unbans);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
src/sfb_pkg.sv
src/sfb_cell.sv
src/syn_flood_blacklister_top.sv
verif/tb.sv
